// ===== rtl/core/utf8_to_utf16_transcoder_assert.svh =====
// Assertion macros for the UTF-8 to UTF-16 transcoder
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Check a property on every clock edge outside reset
`define U8U16_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define U8U16_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/u8u16_pkg.sv =====
// Shared types, constants and functions of the UTF-8 to UTF-16 transcoder
package u8u16_pkg;

    // Queue geometry
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    localparam logic [31:0] MaxCodePoint = 32'h0010_FFFF;
    localparam logic [15:0] HighSurBase  = 16'hD800;
    localparam logic [15:0] LowSurBase   = 16'hDC00;
    localparam logic [20:0] SupBase      = 21'h01_0000;

    typedef enum logic {
        JOB_POINT,
        JOB_REPL
    } t_job_kind;

    // One queued job: a finished sequence or a truncation
    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] acc;
        logic [2:0]  len;
        logic        last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Sequence length set by a lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'd192)      n = 3'd1;
        else if (b < 8'd224) n = 3'd2;
        else if (b < 8'd240) n = 3'd3;
        else if (b < 8'd248) n = 3'd4;
        else if (b < 8'd252) n = 3'd5;
        else                 n = 3'd6;
        return n;
    endfunction

    // Marker bits to strip from the gathered value, by length minus one
    function automatic logic [31:0] length_offset(input logic [2:0] idx);
        logic [31:0] off;
        case (idx)
            3'd1:    off = 32'h0000_3080;
            3'd2:    off = 32'h000E_2080;
            3'd3:    off = 32'h03C8_2080;
            3'd4:    off = 32'hFA08_2080;
            3'd5:    off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/core/u8u16_front.sv =====
// Front end: takes UTF-8 beats, gathers sequences and queues finished jobs
module u8u16_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  u8u16_pkg::t_q_stat   i_stat,
    output logic                 o_push,
    output u8u16_pkg::t_job      o_job
);

    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_remain, n_remain;
    logic [2:0]  r_len, n_len;
    logic        w_accept;
    logic        w_complete;

    assign o_ready  = !i_stat.full;
    assign w_accept = i_valid && o_ready;

    // Gather the next byte and decide whether a job leaves
    always_comb begin
        n_acc      = r_acc;
        n_remain   = r_remain;
        n_len      = r_len;
        w_complete = 1'b0;
        o_push     = 1'b0;
        o_job.kind = u8u16_pkg::JOB_POINT;
        o_job.last = i_last;
        if (r_remain == 3'd0) begin
            n_acc      = {24'd0, i_byte};
            n_len      = u8u16_pkg::lead_length(i_byte);
            n_remain   = n_len - 3'd1;
            w_complete = (n_len == 3'd1);
        end else begin
            n_acc      = {r_acc[25:0], 6'd0} + {24'd0, i_byte};
            n_remain   = r_remain - 3'd1;
            w_complete = (n_remain == 3'd0);
        end
        o_job.acc = n_acc;
        o_job.len = n_len;
        if (w_complete) begin
            o_push = w_accept;
        end else if (i_last) begin
            // Drop the cut-off sequence and emit a replacement
            o_push     = w_accept;
            o_job.kind = u8u16_pkg::JOB_REPL;
            n_remain   = 3'd0;
            n_len      = 3'd0;
        end
    end

    // Advance the sequence state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_remain <= '0;
            r_len    <= '0;
        end else if (w_accept) begin
            r_acc    <= n_acc;
            r_remain <= n_remain;
            r_len    <= n_len;
        end
    end

endmodule

// ===== rtl/core/u8u16_fifo.sv =====
// Short job queue between the front and back ends
module u8u16_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8u16_pkg::t_job      i_job,
    input  logic                 i_pop,
    output u8u16_pkg::t_job      o_head,
    output u8u16_pkg::t_q_stat   o_stat
);

    u8u16_pkg::t_job               r_mem [u8u16_pkg::QDepth];
    logic [u8u16_pkg::QAw-1:0]     r_wp;
    logic [u8u16_pkg::QAw-1:0]     r_rp;
    logic [u8u16_pkg::QAw:0]       r_cnt;

    assign o_stat.full  = (r_cnt == (u8u16_pkg::QAw+1)'(u8u16_pkg::QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Move the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/u8u16_back.sv =====
// Back end: turns queued jobs into UTF-16 beats through an output register
module u8u16_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_repl,
    input  u8u16_pkg::t_job      i_head,
    input  u8u16_pkg::t_q_stat   i_stat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_unit,
    output logic                 o_last_unit,
    output logic                 o_eot
);

    logic        r_valid, n_valid;
    logic [15:0] r_unit, n_unit;
    logic        r_last_unit, n_last_unit;
    logic        r_eot, n_eot;
    logic        r_pend, n_pend;
    logic [15:0] r_low, n_low;
    logic        r_pend_eot, n_pend_eot;

    logic        w_load;
    logic [31:0] w_cp;
    logic [20:0] w_sup;

    assign o_valid     = r_valid;
    assign o_unit      = r_unit;
    assign o_last_unit = r_last_unit;
    assign o_eot       = r_eot;

    // Strip the length markers and find the supplementary offset
    assign w_cp  = i_head.acc - u8u16_pkg::length_offset(i_head.len - 3'd1);
    assign w_sup = w_cp[20:0] - u8u16_pkg::SupBase;

    // Load the output register: pending low surrogate first, then the next job
    always_comb begin
        w_load      = !r_valid || i_ready;
        o_pop       = 1'b0;
        n_valid     = r_valid;
        n_unit      = r_unit;
        n_last_unit = r_last_unit;
        n_eot       = r_eot;
        n_pend      = r_pend;
        n_low       = r_low;
        n_pend_eot  = r_pend_eot;
        if (w_load) begin
            if (r_pend) begin
                n_valid     = 1'b1;
                n_unit      = r_low;
                n_last_unit = 1'b1;
                n_eot       = r_pend_eot;
                n_pend      = 1'b0;
            end else if (!i_stat.empty) begin
                o_pop       = 1'b1;
                n_valid     = 1'b1;
                n_last_unit = 1'b1;
                n_eot       = i_head.last;
                if (i_head.kind == u8u16_pkg::JOB_REPL) begin
                    n_unit = i_repl;
                end else if (w_cp > u8u16_pkg::MaxCodePoint) begin
                    n_unit = i_repl;
                end else if (w_cp[31:16] == 16'd0) begin
                    // Lone surrogate values cannot be encoded
                    n_unit = (w_cp[15:0] inside {[16'hD800:16'hDFFF]}) ? i_repl : w_cp[15:0];
                end else begin
                    // Split into a surrogate pair, high unit first
                    n_unit      = u8u16_pkg::HighSurBase + {6'd0, w_sup[19:10]};
                    n_last_unit = 1'b0;
                    n_eot       = 1'b0;
                    n_pend      = 1'b1;
                    n_low       = u8u16_pkg::LowSurBase + {6'd0, w_sup[9:0]};
                    n_pend_eot  = i_head.last;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Hold or advance the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit      <= n_unit;
        r_last_unit <= n_last_unit;
        r_eot       <= n_eot;
        r_low       <= n_low;
        r_pend_eot  <= n_pend_eot;
    end

endmodule

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder
// A beat that finishes a sequence passes through the job queue and then the output register.
// Throughput: one input byte per cycle while the queue is not full; a surrogate pair holds the output
// port for two units while a four-job queue keeps taking bytes.
// Reset (synchronous, active low) clears the sequence state, the queue, the output valid and pending-pair
// flags and sets the replacement unit to zero; no clearing pass is needed.
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic [0:0]  m_axis_tuser,   // [0] last_unit
    output logic        m_axis_tlast    // end_of_text
);

    logic [15:0]          r_repl;
    logic                 w_push;
    logic                 w_pop;
    u8u16_pkg::t_job      w_job;
    u8u16_pkg::t_job      w_head;
    u8u16_pkg::t_q_stat   w_stat;

    // Replacement unit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= '0;
        end else if (i_cfg_wen) begin
            r_repl <= i_cfg_wdata;
        end
    end

    u8u16_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    u8u16_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_repl      (r_repl),
        .i_head      (w_head),
        .i_stat      (w_stat),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_unit      (m_axis_tdata),
        .o_last_unit (m_axis_tuser[0]),
        .o_eot       (m_axis_tlast)
    );

`include "utf8_to_utf16_transcoder_assert.svh"

    `U8U16_ASSERT(a_no_push_full, !(w_push && w_stat.full), "job pushed into a full queue")
    `U8U16_ASSERT(a_no_pop_empty, !(w_pop && w_stat.empty), "job popped from an empty queue")
    `U8U16_ASSERT(a_eot_is_last, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0], "end of text on a non-final unit")
    `U8U16_ASSERT(a_pair_follows, m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=> m_axis_tvalid && m_axis_tuser[0], "low surrogate missing after high unit")
    `U8U16_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !m_axis_tvalid, "output valid right after reset")

endmodule
